// File: hw/rtl/ljd_pkg.sv
package ljd_pkg;

    localparam int LINE_SAMPLES      = 8192;
    localparam int SYMBOLS_PER_TABLE = 256;
    localparam int TABLE_COUNT       = 4;
    localparam int CODE_LENGTHS      = 16;
    localparam int MAX_DIFF_SIZE     = 16;

    localparam int LINE_AW   = $clog2(LINE_SAMPLES);
    localparam int COUNT_BASE = TABLE_COUNT * SYMBOLS_PER_TABLE;
    localparam int TBL_DEPTH = TABLE_COUNT * (SYMBOLS_PER_TABLE + CODE_LENGTHS);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CNT_IW    = $clog2(TABLE_COUNT * CODE_LENGTHS);

    localparam logic [2:0] CMD_COUNT  = 3'd0;
    localparam logic [2:0] CMD_SYMBOL = 3'd1;
    localparam logic [2:0] CMD_DATA   = 3'd2;
    localparam logic [2:0] CMD_FILLER = 3'd3;
    localparam logic [2:0] CMD_START  = 3'd4;

    localparam logic [2:0] REG_PRECISION    = 3'd0;
    localparam logic [2:0] REG_WIDTH        = 3'd1;
    localparam logic [2:0] REG_HEIGHT       = 3'd2;
    localparam logic [2:0] REG_COMPONENTS   = 3'd3;
    localparam logic [2:0] REG_PREDICTOR    = 3'd4;
    localparam logic [2:0] REG_POINT_XFORM  = 3'd5;
    localparam logic [2:0] REG_TABLE_SELECT = 3'd6;

    localparam logic [7:0] BYTE_FF = 8'hFF;

    typedef struct packed {
        logic [4:0]  precision;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [2:0]  component_count;
        logic [2:0]  predictor;
        logic [3:0]  point_transform;
        logic [7:0]  table_select;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic              is_count;
        logic [CNT_IW-1:0] cidx;
        logic [TBL_AW-1:0] addr;
        logic [7:0]        data;
    } t_tbl_wr;

    typedef struct packed {
        logic        valid;
        logic [15:0] d;
    } t_diff_req;

    typedef struct packed {
        logic       idle;
        logic       frame_done;
        logic [1:0] comp;
    } t_pred_stat;

    // One line store entry: the tag names the line that last wrote it, prev keeps
    // the value the entry had when that line began.
    typedef struct packed {
        logic [15:0] epoch;
        logic [15:0] row;
        logic [15:0] prev;
        logic [15:0] val;
    } t_line_entry;

    localparam int LINE_W = $bits(t_line_entry);

    typedef enum logic [0:0] {FEED_IDLE, FEED_BITS} t_feed_st;
    typedef enum logic [2:0] {H_IDLE, H_CNT, H_SYM, H_EMIT} t_huff_st;
    typedef enum logic [2:0] {P_IDLE, P_RDA, P_RDB, P_CALC, P_OUT, P_ERR} t_pred_st;

endpackage

// File: hw/rtl/lossless_jpeg_scan_decoder_core.sv
// Channel  | direction | tdata (low bit up)                | tuser | tlast
// s_axis   | in        | table_id[1:0] slot[9:2] value[17:10] | cmd   | -
// m_axis   | out       | sample[15:0] component[17:16]       | error | last
// cfg      | in        | register index, 16-bit write data   | -     | -
//
// Table words do not stall the input. A data byte is accepted and is then shifted
// out one bit at a time; each code bit needs a code count read from the table memory,
// a code that matches a symbol read as well, and each sample a handoff and line store
// access. Reset is synchronous; no clearing pass.
// A waiting output word holds the next sample in the predictor, which then stalls the input.
module lossless_jpeg_scan_decoder_core import ljd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // table_id, slot, value
    input  logic [2:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // sample, component
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // error
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg       r_cfg;
    t_feed_st   r_fstate;
    logic [7:0] r_byte;
    logic [3:0] r_bits;
    logic       r_pending, r_ended;

    t_tbl_wr    tbl_wr;
    t_pred_stat pred_stat;
    t_diff_req  diff;
    logic       huff_idle, bit_ready, accept, start;
    logic [1:0] tid;
    logic [7:0] slot, value;
    logic       feed;
    logic [7:0] feed_byte;
    logic [15:0] sample;
    logic [1:0]  component;

    assign tid   = s_axis_tdata[1:0];
    assign slot  = s_axis_tdata[9:2];
    assign value = s_axis_tdata[17:10];

    assign s_axis_tready = (r_fstate == FEED_IDLE) && huff_idle && pred_stat.idle;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign start  = accept && (s_axis_tuser == CMD_START);

    always_comb begin
        tbl_wr      = '0;
        tbl_wr.data = value;
        tbl_wr.cidx = CNT_IW'(32'(tid) * CODE_LENGTHS + 32'(slot[3:0]));
        if (accept && s_axis_tuser == CMD_COUNT && 32'(slot) < CODE_LENGTHS
            && 32'(tid) < TABLE_COUNT) begin
            tbl_wr.en       = 1'b1;
            tbl_wr.is_count = 1'b1;
            tbl_wr.addr     = TBL_AW'(COUNT_BASE + 32'(tbl_wr.cidx));
        end else if (accept && s_axis_tuser == CMD_SYMBOL && 32'(slot) < SYMBOLS_PER_TABLE
                     && 32'(tid) < TABLE_COUNT) begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = TBL_AW'(32'(tid) * SYMBOLS_PER_TABLE + 32'(slot));
        end
    end

    // Byte stuffing: FF 00 is a literal FF, FF followed by anything else is a marker.
    always_comb begin
        feed      = 1'b0;
        feed_byte = '0;
        if (s_axis_tuser == CMD_DATA) begin
            if (r_ended) begin
                feed = 1'b1;
            end else if (r_pending) begin
                feed      = 1'b1;
                feed_byte = (value == 8'd0) ? BYTE_FF : 8'd0;
            end else if (value != BYTE_FF) begin
                feed      = 1'b1;
                feed_byte = value;
            end
        end else if (s_axis_tuser == CMD_FILLER) begin
            feed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.precision       <= 5'd16;
            r_cfg.frame_width     <= 16'd1;
            r_cfg.frame_height    <= 16'd1;
            r_cfg.component_count <= 3'd1;
            r_cfg.predictor       <= 3'd1;
            r_cfg.point_transform <= 4'd0;
            r_cfg.table_select    <= 8'd0;
            r_fstate  <= FEED_IDLE;
            r_bits    <= '0;
            r_pending <= 1'b0;
            r_ended   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PRECISION:    r_cfg.precision       <= i_cfg_wdata[4:0];
                    REG_WIDTH:        r_cfg.frame_width     <= i_cfg_wdata;
                    REG_HEIGHT:       r_cfg.frame_height    <= i_cfg_wdata;
                    REG_COMPONENTS:   r_cfg.component_count <= i_cfg_wdata[2:0];
                    REG_PREDICTOR:    r_cfg.predictor       <= i_cfg_wdata[2:0];
                    REG_POINT_XFORM:  r_cfg.point_transform <= i_cfg_wdata[3:0];
                    REG_TABLE_SELECT: r_cfg.table_select    <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            unique case (r_fstate)
                FEED_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser == CMD_DATA) begin
                            if (!r_ended) begin
                                if (r_pending) begin
                                    r_pending <= 1'b0;
                                    r_ended   <= (value != 8'd0);
                                end else if (value == BYTE_FF) begin
                                    r_pending <= 1'b1;
                                end
                            end
                        end else if (s_axis_tuser == CMD_FILLER) begin
                            r_pending <= 1'b0;
                            r_ended   <= 1'b1;
                        end else if (s_axis_tuser == CMD_START) begin
                            r_pending <= 1'b0;
                            r_ended   <= 1'b0;
                        end
                        if (feed) begin
                            r_byte   <= feed_byte;
                            r_bits   <= 4'd8;
                            r_fstate <= FEED_BITS;
                        end
                    end
                end
                FEED_BITS: begin
                    if (bit_ready) begin
                        r_byte <= {r_byte[6:0], 1'b0};
                        r_bits <= r_bits - 4'd1;
                        if (r_bits == 4'd1) begin
                            r_fstate <= FEED_IDLE;
                        end
                    end
                end
                default: r_fstate <= FEED_IDLE;
            endcase
        end
    end

    ljd_huff u_huff (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_table_select (r_cfg.table_select),
        .i_tbl_wr       (tbl_wr),
        .i_clear        (start),
        .i_bit_valid    (r_fstate == FEED_BITS),
        .i_bit          (r_byte[7]),
        .o_bit_ready    (bit_ready),
        .i_pred         (pred_stat),
        .o_diff         (diff),
        .o_idle         (huff_idle)
    );

    ljd_pred u_pred (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (start),
        .i_diff      (diff),
        .o_stat      (pred_stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_sample    (sample),
        .o_component (component),
        .o_last      (m_axis_tlast),
        .o_error     (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, component, sample};

endmodule

// File: hw/rtl/ljd_ram.sv
module ljd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/ljd_huff.sv
module ljd_huff import ljd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_table_select,
    input  t_tbl_wr    i_tbl_wr,
    input  logic       i_clear,
    input  logic       i_bit_valid,
    input  logic       i_bit,
    output logic       o_bit_ready,
    input  t_pred_stat i_pred,
    output t_diff_req  o_diff,
    output logic       o_idle
);

    function automatic logic [15:0] diff_value(input logic [15:0] v, input logic [4:0] s);
        logic [16:0] half;
        logic [16:0] full;
        half = 17'd1 << (s - 5'd1);
        full = (17'd1 << s) - 17'd1;
        return ({1'b0, v} < half) ? 16'(v - full[15:0]) : v;
    endfunction

    t_huff_st r_state, n_state;
    logic [16:0] r_partial, n_partial;
    logic [4:0]  r_len, n_len;
    logic [23:0] r_first, n_first;
    logic [11:0] r_base, n_base;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_cval, n_cval;
    logic        r_phase, n_phase;
    logic [4:0]  r_dsize, n_dsize;
    logic [15:0] r_dbits, n_dbits;
    logic [15:0] r_d, n_d;
    logic [TABLE_COUNT*CODE_LENGTHS-1:0] r_cnt_vld;

    logic [TBL_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [1:0]        tsel;
    logic              t_ok;
    logic [CNT_IW-1:0] cnt_idx;
    logic              bit_take;
    logic [7:0]        cnt;
    logic [23:0]       off;
    logic              hit;
    logic [11:0]       k;
    logic              fin;
    logic [7:0]        fin_sym;
    logic [4:0]        size;

    ljd_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (i_tbl_wr.en),
        .i_waddr (i_tbl_wr.addr),
        .i_wdata (i_tbl_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign tsel    = 2'(i_table_select >> {i_pred.comp, 1'b0});
    assign t_ok    = 32'(tsel) < TABLE_COUNT;
    assign cnt_idx = CNT_IW'(32'(tsel) * CODE_LENGTHS + 32'(r_len[3:0]));
    assign o_idle      = (r_state == H_IDLE);
    assign o_bit_ready = (r_state == H_IDLE) && i_pred.idle && !i_clear;
    assign bit_take    = i_bit_valid && o_bit_ready;

    always_comb begin
        n_state   = r_state;
        n_partial = r_partial;
        n_len     = r_len;
        n_first   = r_first;
        n_base    = r_base;
        n_cnt     = r_cnt;
        n_cval    = r_cval;
        n_phase   = r_phase;
        n_dsize   = r_dsize;
        n_dbits   = r_dbits;
        n_d       = r_d;
        rd_addr   = TBL_AW'(COUNT_BASE + 32'(cnt_idx));
        o_diff    = '0;
        fin       = 1'b0;
        fin_sym   = '0;
        cnt       = r_cval ? rd_data : 8'd0;
        off       = 24'(r_partial) - r_first;
        hit       = (24'(r_partial) >= r_first) && (off < 24'(cnt));
        k         = r_base + 12'(off[7:0]);
        size      = '0;
        unique case (r_state)
            H_IDLE: begin
                if (i_clear) begin
                    n_partial = '0;
                    n_len     = '0;
                    n_phase   = 1'b0;
                    n_dsize   = '0;
                    n_dbits   = '0;
                end else if (bit_take && !i_pred.frame_done) begin
                    if (!r_phase) begin
                        n_partial = {r_partial[15:0], i_bit};
                        n_len     = r_len + 5'd1;
                        if (r_len == 5'd0) begin
                            n_first = '0;
                            n_base  = '0;
                        end else begin
                            n_first = (r_first + 24'(r_cnt)) << 1;
                            n_base  = r_base + 12'(r_cnt);
                        end
                        n_cval  = r_cnt_vld[cnt_idx] && t_ok;
                        n_state = H_CNT;
                    end else begin
                        n_dbits = {r_dbits[14:0], i_bit};
                        n_len   = r_len + 5'd1;
                        if (n_len == r_dsize) begin
                            n_d     = diff_value(n_dbits, r_dsize);
                            n_phase = 1'b0;
                            n_len   = '0;
                            n_dbits = '0;
                            n_state = H_EMIT;
                        end
                    end
                end
            end
            H_CNT: begin
                n_cnt = cnt;
                if (hit) begin
                    if (32'(k) < SYMBOLS_PER_TABLE) begin
                        rd_addr = TBL_AW'(32'(tsel) * SYMBOLS_PER_TABLE + 32'(k));
                        n_state = H_SYM;
                    end else begin
                        fin = 1'b1;
                    end
                end else if (32'(r_len) < CODE_LENGTHS) begin
                    n_state = H_IDLE;
                end else begin
                    fin = 1'b1;
                end
            end
            H_SYM: begin
                fin     = 1'b1;
                fin_sym = rd_data;
            end
            H_EMIT: begin
                o_diff.valid = 1'b1;
                o_diff.d     = r_d;
                if (i_pred.idle) begin
                    n_state = H_IDLE;
                end
            end
            default: n_state = H_IDLE;
        endcase

        if (fin) begin
            n_partial = '0;
            n_len     = '0;
            size = (32'(fin_sym) > MAX_DIFF_SIZE) ? 5'(MAX_DIFF_SIZE) : fin_sym[4:0];
            if (size == 5'd0) begin
                n_d     = '0;
                n_state = H_EMIT;
            end else if (32'(size) == MAX_DIFF_SIZE) begin
                n_d     = 16'h8000;
                n_state = H_EMIT;
            end else begin
                n_phase = 1'b1;
                n_dsize = size;
                n_dbits = '0;
                n_state = H_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= H_IDLE;
            r_partial <= '0;
            r_len     <= '0;
            r_first   <= '0;
            r_base    <= '0;
            r_cnt     <= '0;
            r_cval    <= 1'b0;
            r_phase   <= 1'b0;
            r_dsize   <= '0;
            r_dbits   <= '0;
            r_cnt_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_partial <= n_partial;
            r_len     <= n_len;
            r_first   <= n_first;
            r_base    <= n_base;
            r_cnt     <= n_cnt;
            r_cval    <= n_cval;
            r_phase   <= n_phase;
            r_dsize   <= n_dsize;
            r_dbits   <= n_dbits;
            if (i_tbl_wr.en && i_tbl_wr.is_count) begin
                r_cnt_vld[i_tbl_wr.cidx] <= 1'b1;
            end
        end
        r_d <= n_d;
    end

endmodule

// File: hw/rtl/ljd_pred.sv
module ljd_pred import ljd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_start,
    input  t_diff_req   i_diff,
    output t_pred_stat  o_stat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_sample,
    output logic [1:0]  o_component,
    output logic        o_last,
    output logic        o_error
);

    function automatic logic [15:0] above(input t_line_entry x, input logic [31:0] tag);
        return ({x.epoch, x.row} == tag) ? x.prev : x.val;
    endfunction

    t_pred_st r_state, n_state;
    logic [15:0] r_row, r_col, r_epoch;
    logic [1:0]  r_comp;
    logic        r_done;
    logic [15:0] r_d;
    logic [1:0]  r_c;
    logic [LINE_AW-1:0] r_idx;
    t_line_entry r_a, r_b;
    logic [15:0] r_val;
    logic        r_last;
    logic        r_out_valid;
    logic [15:0] r_out_sample;
    logic [1:0]  r_out_comp;
    logic        r_out_last;
    logic        r_out_err;

    logic [15:0] w_eff, h_eff;
    logic [2:0]  nc;
    logic [1:0]  c_eff;
    logic [18:0] span, idx_full;
    logic        too_long;
    logic [LINE_AW-1:0] rd_addr;
    t_line_entry rd_data, wr_entry;
    logic        out_free, mem_we, out_load;
    logic [31:0] cur_tag;
    logic [4:0]  prec;
    logic signed [6:0] e_s;
    logic [3:0]  e;
    logic signed [17:0] ra, rb, rc, p;
    logic [15:0] pred;
    logic [2:0]  c_next;
    logic [16:0] col_next;

    assign w_eff = (i_cfg.frame_width == 16'd0) ? 16'd1 : i_cfg.frame_width;
    assign h_eff = (i_cfg.frame_height == 16'd0) ? 16'd1 : i_cfg.frame_height;
    assign nc = (i_cfg.component_count == 3'd0) ? 3'd1 :
                (i_cfg.component_count > 3'd4) ? 3'd4 : i_cfg.component_count;
    assign c_eff    = ({1'b0, r_comp} >= nc) ? 2'd0 : r_comp;
    assign span     = 19'(w_eff) * 19'(nc);
    assign too_long = span > 19'(LINE_SAMPLES);
    assign idx_full = 19'(r_col) * 19'(nc) + 19'(c_eff);
    assign cur_tag  = {r_epoch, r_row};
    assign out_free = !r_out_valid || i_out_ready;
    assign mem_we   = (r_state == P_OUT) && out_free;
    assign out_load = out_free && ((r_state == P_OUT) || (r_state == P_ERR));

    assign wr_entry.epoch = r_epoch;
    assign wr_entry.row   = r_row;
    assign wr_entry.prev  = above(r_b, cur_tag);
    assign wr_entry.val   = r_val;

    ljd_ram #(.WIDTH(LINE_W), .DEPTH(LINE_SAMPLES)) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Idle: left neighbor, or component's first sample in column 0; else own index.
    always_comb begin
        if (r_state == P_IDLE) begin
            rd_addr = (r_col == 16'd0) ? LINE_AW'(c_eff) : LINE_AW'(idx_full - 19'(nc));
        end else begin
            rd_addr = r_idx;
        end
    end

    always_comb begin
        prec = (i_cfg.precision > 5'd16) ? 5'd16 : i_cfg.precision;
        e_s  = $signed({2'b00, prec}) - $signed({3'b000, i_cfg.point_transform}) - 7'sd1;
        e    = (e_s < 0) ? 4'd0 : e_s[3:0];
        ra   = $signed({2'b00, r_a.val});
        rb   = $signed({2'b00, above(r_b, cur_tag)});
        rc   = $signed({2'b00, above(r_a, cur_tag)});
        unique case (i_cfg.predictor)
            3'd2:    p = rb;
            3'd3:    p = rc;
            3'd4:    p = ra + rb - rc;
            3'd5:    p = ra + ((rb - rc) >>> 1);
            3'd6:    p = rb + ((ra - rc) >>> 1);
            3'd7:    p = (ra + rb) >>> 1;
            default: p = ra;
        endcase
        if (r_col == 16'd0) begin
            pred = (r_row == 16'd0) ? 16'(17'd1 << e) : above(r_a, cur_tag);
        end else if (r_row == 16'd0) begin
            pred = r_a.val;
        end else begin
            pred = p[15:0];
        end
    end

    assign c_next   = {1'b0, r_c} + 3'd1;
    assign col_next = {1'b0, r_col} + 17'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            P_IDLE: begin
                if (i_start) begin
                    n_state = too_long ? P_ERR : P_IDLE;
                end else if (i_diff.valid) begin
                    n_state = (too_long || idx_full >= 19'(LINE_SAMPLES)) ? P_ERR : P_RDA;
                end
            end
            P_RDA:  n_state = P_RDB;
            P_RDB:  n_state = P_CALC;
            P_CALC: n_state = P_OUT;
            P_OUT:  n_state = out_free ? P_IDLE : P_OUT;
            P_ERR:  n_state = out_free ? P_IDLE : P_ERR;
            default: n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= P_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_comp      <= '0;
            r_done      <= 1'b0;
            r_epoch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_comp  <= '0;
                        r_done  <= 1'b0;
                        r_epoch <= r_epoch + 16'd1;
                    end else if (i_diff.valid) begin
                        r_d   <= i_diff.d;
                        r_c   <= c_eff;
                        r_idx <= LINE_AW'(idx_full);
                    end
                end
                P_RDA: r_a <= rd_data;
                P_RDB: r_b <= rd_data;
                P_CALC: begin
                    r_val  <= pred + r_d;
                    r_last <= ({1'b0, r_row} + 17'd1 >= {1'b0, h_eff})
                           && (col_next >= {1'b0, w_eff}) && (c_next >= nc);
                end
                P_OUT: begin
                    if (out_free) begin
                        r_out_sample <= 16'(r_val << i_cfg.point_transform);
                        r_out_comp   <= r_c;
                        r_out_last   <= r_last;
                        r_out_err    <= 1'b0;
                        if (r_last) begin
                            r_done <= 1'b1;
                        end
                        if (c_next >= nc) begin
                            r_comp <= '0;
                            if (col_next >= {1'b0, w_eff}) begin
                                r_col <= '0;
                                r_row <= r_row + 16'd1;
                            end else begin
                                r_col <= col_next[15:0];
                            end
                        end else begin
                            r_comp <= c_next[1:0];
                        end
                    end
                end
                P_ERR: begin
                    if (out_free) begin
                        r_out_sample <= '0;
                        r_out_comp   <= '0;
                        r_out_last   <= 1'b0;
                        r_out_err    <= 1'b1;
                        r_done       <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.idle       = (r_state == P_IDLE);
    assign o_stat.frame_done = r_done;
    assign o_stat.comp       = r_comp;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_component = r_out_comp;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

endmodule

// File: hw/rtl/ljd_checker.sv
module ljd_checker import ljd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // No word may be left over from before reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // An error word carries no sample and never ends the frame.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0 && !m_axis_tlast)
        else $error("error word with payload");

    // Table words leave the block ready again in the next cycle.
    a_table_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tuser == CMD_COUNT || s_axis_tuser == CMD_SYMBOL) |=> s_axis_tready)
        else $error("table word stalled the input");

endmodule

bind lossless_jpeg_scan_decoder_core ljd_checker u_checker (.*);
